FILE: rtl/fqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_pkg: shared types and constants
// Sizes, request and status codes, and the control bundle that the queue
// controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package fqd_pkg;

	// Queue depth and word size.
	localparam int DEPTH      = 16;
	localparam int ITEM_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Full level in the width of the counter.
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	// Request kinds.
	typedef enum logic [1:0] {
		MODE_ENQ = 2'd0,
		MODE_DEQ = 2'd1,
		MODE_DEL = 2'd2,
		MODE_NOP = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	// Per-cycle command seen by every cell.
	typedef struct packed {
		logic                  enq;
		logic                  deq;
		logic                  del;
		logic [ITEM_WIDTH-1:0] item;
	} cell_ctl_t;

endpackage

FILE: rtl/fifo_queue_with_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete: bounded queue with removal by value
// A row of slot cells, head in cell 0, that shift toward the head to close
// gaps.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  request  | in_valid / in_ready   | mode, item_value
//  result   | out_valid / out_ready | status, item_out, is_empty, occupancy
//
// One request per cycle while results are taken: a request goes into the cell
// row in its accept cycle; the output register holds its result next cycle.
// The delete match is one compare per cell plus a ripple along the row.
// Reset empties the queue and the output register; no clearing pass.
// in_ready is high while the output register is empty or being taken, so a
// stalled result holds back only the next request.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete
	import fqd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [ITEM_WIDTH-1:0] item_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [ITEM_WIDTH-1:0] item_out,
	output logic                  is_empty,
	output logic [CNT_W-1:0]      occupancy
);

	logic                  out_valid_q;
	status_t               status_q;
	logic [ITEM_WIDTH-1:0] item_out_q;
	logic                  is_empty_q;
	logic [CNT_W-1:0]      count_q;

	logic                  accept;
	mode_t                 req_mode;
	logic                  full;
	logic                  empty;
	cell_ctl_t             ctl;
	status_t               status_d;
	logic [CNT_W-1:0]      count_d;
	logic [ITEM_WIDTH-1:0] item_out_d;

	logic                  occ_chain   [DEPTH+2];
	logic                  found_chain [DEPTH+1];
	logic [ITEM_WIDTH-1:0] data_chain  [DEPTH+1];

	// Request handshake.
	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;
	assign req_mode = mode_t'(mode);
	assign full     = (count_q == DEPTH_CNT);
	assign empty    = (count_q == '0);

	// Command broadcast to the cells.
	always_comb begin
		ctl.enq  = accept && (req_mode == MODE_ENQ) && !full;
		ctl.deq  = accept && (req_mode == MODE_DEQ) && !empty;
		ctl.del  = accept && (req_mode == MODE_DEL);
		ctl.item = item_value;
	end

	// Row ends: the slot ahead of the head counts as occupied, and an empty
	// slot holding a zero word lies behind the last one.
	assign occ_chain[0]         = 1'b1;
	assign occ_chain[DEPTH + 1] = 1'b0;
	assign found_chain[0]       = 1'b0;
	assign data_chain[DEPTH]    = '0;

	// Cell row. Cell i shows its occupied flag on index i+1 of the occupied
	// chain and its word on index i of the data chain.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		fqd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_occ  (occ_chain[i]),
			.found_in  (found_chain[i]),
			.next_occ  (occ_chain[i + 2]),
			.next_data (data_chain[i + 1]),
			.found_out (found_chain[i + 1]),
			.occ       (occ_chain[i + 1]),
			.data      (data_chain[i])
		);
	end

	// Result and new count for the accepted request.
	always_comb begin
		status_d   = ST_MISS;
		count_d    = count_q;
		item_out_d = '0;
		unique case (req_mode)
			MODE_ENQ: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_OK;
					count_d  = count_q + CNT_W'(1);
				end
			end
			MODE_DEQ: begin
				if (!empty) begin
					status_d   = ST_OK;
					count_d    = count_q - CNT_W'(1);
					item_out_d = data_chain[0];
				end
			end
			MODE_DEL: begin
				if (found_chain[DEPTH]) begin
					status_d = ST_OK;
					count_d  = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_MISS;
			end
		endcase
	end

	// Occupancy counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status_d;
			item_out_q <= item_out_d;
			is_empty_q <= (count_d == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item_out  = item_out_q;
	assign is_empty  = is_empty_q;
	assign occupancy = count_q;

endmodule

FILE: rtl/fqd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_cell: one queue slot
// Holds one entry and its occupied flag. Takes the entry of its younger
// neighbor on a dequeue or on a delete at or ahead of it, and loads the new
// item when it is the first free slot on an enqueue.
// ----------------------------------------------------------------------------
module fqd_cell
	import fqd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic                  prev_occ,
	input  logic                  found_in,
	input  logic                  next_occ,
	input  logic [ITEM_WIDTH-1:0] next_data,
	output logic                  found_out,
	output logic                  occ,
	output logic [ITEM_WIDTH-1:0] data
);

	logic                  occ_q;
	logic [ITEM_WIDTH-1:0] data_q;
	logic                  hit;
	logic                  tail;
	logic                  shift;

	// Match and tail detection from local state and the neighbors.
	assign hit       = occ_q && (data_q == ctl.item);
	assign found_out = found_in | hit;
	assign tail      = prev_occ & ~occ_q;
	assign shift     = ctl.deq | (ctl.del & found_out);

	// Occupied flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (shift) begin
			occ_q <= next_occ;
		end else if (ctl.enq && tail) begin
			occ_q <= 1'b1;
		end
	end

	// Entry word; meaningful only while occupied.
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_data;
		end else if (ctl.enq && tail) begin
			data_q <= ctl.item;
		end
	end

	assign occ  = occ_q;
	assign data = data_q;

endmodule

FILE: tb/fifo_queue_with_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_tb: self-checking bench for the bounded queue
// Drives enqueue, dequeue, delete-by-value and unused-mode requests. A short
// stimulus table comes first, then phases of random traffic that lean toward
// filling, draining or neither. A queue model inside the bench predicts each
// result the table does not give, and every result is checked field by field
// in arrival order. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_tb
	import fqd_pkg::*;
();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_PHASES  = 14;
	localparam int PHASE_ITEMS  = 58;
	localparam int LONG_HOLD    = 120;
	localparam int WORD_POOL_SZ = 6;

	// One result of the queue, as the bench expects it.
	typedef struct packed {
		status_t               status;
		logic [ITEM_WIDTH-1:0] word;
		logic                  empty;
		logic [CNT_W-1:0]      occ;
	} queue_result_t;

	// One row of the stimulus table. Rows with reps above one enqueue
	// consecutive words starting at word.
	typedef struct packed {
		mode_t                 op;
		logic [ITEM_WIDTH-1:0] word;
		logic [7:0]            reps;
		logic                  typed;
		queue_result_t         res;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            mode;
	logic [ITEM_WIDTH-1:0] item_value;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            status;
	logic [ITEM_WIDTH-1:0] item_out;
	logic                  is_empty;
	logic [CNT_W-1:0]      occupancy;

	// Bench copy of the queue contents, head first.
	logic [ITEM_WIDTH-1:0] held_words[$];
	// Results still owed by the block, oldest first.
	queue_result_t         awaited_results[$];
	logic [ITEM_WIDTH-1:0] word_pool[WORD_POOL_SZ];
	int                    mismatch_count = 0;
	int                    results_seen   = 0;
	int                    sink_style     = 0;
	int                    cycle_count    = 0;

	// Directed requests: empty queue, extremes, duplicates, head, middle and
	// tail deletes, a miss, filling to the top, and the unused mode.
	stim_row_t directed_rows [0:20] = '{
		'{MODE_DEQ, 32'h0000_0000, 8'd1, 1'b1, '{ST_MISS, 32'h0, 1'b1, 5'd0}},
		'{MODE_DEL, 32'h0000_0000, 8'd1, 1'b1, '{ST_MISS, 32'h0, 1'b1, 5'd0}},
		'{MODE_NOP, 32'hFFFF_FFFF, 8'd1, 1'b1, '{ST_MISS, 32'h0, 1'b1, 5'd0}},
		'{MODE_ENQ, 32'hFFFF_FFFF, 8'd1, 1'b1, '{ST_OK,   32'h0, 1'b0, 5'd1}},
		'{MODE_ENQ, 32'h0000_0000, 8'd1, 1'b1, '{ST_OK,   32'h0, 1'b0, 5'd2}},
		'{MODE_ENQ, 32'hA5A5_A5A5, 8'd1, 1'b1, '{ST_OK,   32'h0, 1'b0, 5'd3}},
		'{MODE_ENQ, 32'h5A5A_5A5A, 8'd1, 1'b1, '{ST_OK,   32'h0, 1'b0, 5'd4}},
		'{MODE_ENQ, 32'hA5A5_A5A5, 8'd1, 1'b1, '{ST_OK,   32'h0, 1'b0, 5'd5}},
		'{MODE_DEL, 32'hA5A5_A5A5, 8'd1, 1'b0, '0},
		'{MODE_DEL, 32'h1234_5678, 8'd1, 1'b1, '{ST_MISS, 32'h0, 1'b0, 5'd4}},
		'{MODE_DEL, 32'hA5A5_A5A5, 8'd1, 1'b0, '0},
		'{MODE_DEL, 32'hFFFF_FFFF, 8'd1, 1'b0, '0},
		'{MODE_DEQ, 32'h0000_0000, 8'd1, 1'b0, '0},
		'{MODE_DEQ, 32'hFFFF_FFFF, 8'd1, 1'b0, '0},
		'{MODE_ENQ, 32'h8000_0000, 8'd16, 1'b0, '0},
		'{MODE_ENQ, 32'h7FFF_FFFF, 8'd1, 1'b1, '{ST_FULL, 32'h0, 1'b0, 5'd16}},
		'{MODE_DEL, 32'h8000_000F, 8'd1, 1'b0, '0},
		'{MODE_ENQ, 32'hDEAD_BEEF, 8'd1, 1'b0, '0},
		'{MODE_NOP, 32'h0000_0000, 8'd1, 1'b0, '0},
		'{MODE_DEL, 32'h8000_0000, 8'd1, 1'b0, '0},
		'{MODE_DEQ, 32'h0000_0000, 8'd1, 1'b0, '0}
	};

	fifo_queue_with_delete i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.item_out   (item_out),
		.is_empty   (is_empty),
		.occupancy  (occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the queue model and return the result it owes.
	function automatic queue_result_t next_queue_result(mode_t op,
			logic [ITEM_WIDTH-1:0] word);
		queue_result_t r;
		int            i;
		int            hit;
		r.status = ST_MISS;
		r.word   = '0;
		hit      = -1;
		case (op)
			MODE_ENQ: begin
				if (held_words.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					held_words.push_back(word);
					r.status = ST_OK;
				end
			end
			MODE_DEQ: begin
				if (held_words.size() > 0) begin
					r.word   = held_words.pop_front();
					r.status = ST_OK;
				end
			end
			MODE_DEL: begin
				// Only the oldest matching entry goes; younger ones keep order.
				for (i = 0; i < held_words.size() && hit < 0; i++)
					if (held_words[i] == word)
						hit = i;
				if (hit >= 0) begin
					held_words.delete(hit);
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		r.empty = (held_words.size() == 0);
		r.occ   = CNT_W'(held_words.size());
		return r;
	endfunction

	// Idle cycles before the next request or result: none, occasional or heavy.
	function automatic int draw_gap(int style);
		case (style)
			0:       return 0;
			1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
			default: return $urandom_range(0, 17);
		endcase
	endfunction

	// Words that often repeat, plus extremes and a single set bit.
	function automatic logic [ITEM_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1, 2:    return word_pool[$urandom_range(0, WORD_POOL_SZ - 1)];
			default: begin
				case ($urandom_range(0, 2))
					0:       return '0;
					1:       return '1;
					default: return ITEM_WIDTH'(1) << $urandom_range(0, ITEM_WIDTH - 1);
				endcase
			end
		endcase
	endfunction

	// Offer one request, wait for its acceptance and record the expected result.
	task automatic push_request(input mode_t op, input logic [ITEM_WIDTH-1:0] word,
			input bit typed, input queue_result_t typed_res, input int gap);
		queue_result_t predicted;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= op;
		item_value <= word;
		do @(posedge clk); while (!in_ready);
		predicted = next_queue_result(op, word);
		awaited_results.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	// Stop offering until every owed result has come back.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
	endtask

	// Result side: random stalls, two long hold-offs, and the field checks.
	initial begin : result_sink
		int            hold;
		queue_result_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (results_seen % 40 == 0)
				sink_style = $urandom_range(0, 2);
			if (results_seen == 150 || results_seen == 520)
				hold = LONG_HOLD;
			else
				hold = draw_gap(sink_style);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (awaited_results.size() == 0) begin
				$error("result with no request waiting: status %0d, item_out %h",
					status, item_out);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
				if (item_out !== want.word) begin
					$error("item_out: expected %h, got %h", want.word, item_out);
					mismatch_count++;
				end
				if (is_empty !== want.empty) begin
					$error("is_empty: expected %0d, got %0d", want.empty, is_empty);
					mismatch_count++;
				end
				if (occupancy !== want.occ) begin
					$error("occupancy: expected %0d, got %0d", want.occ, occupancy);
					mismatch_count++;
				end
			end
			results_seen++;
			@(negedge clk);
		end
	end

	// Run limit.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("fifo_queue_with_delete: mismatch");
		$finish;
	end

	// Request side: reset, the stimulus table, then random phases.
	initial begin : request_source
		int                    row;
		int                    k;
		int                    phase;
		int                    n;
		int                    bias;
		int                    src_style;
		int                    pick;
		int                    enq_pct;
		int                    deq_pct;
		mode_t                 op;
		logic [ITEM_WIDTH-1:0] word;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_ENQ;
		item_value = '0;
		for (k = 0; k < WORD_POOL_SZ; k++)
			word_pool[k] = $urandom;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the stimulus table.
		for (row = 0; row <= 20; row++)
			for (k = 0; k < directed_rows[row].reps; k++)
				push_request(directed_rows[row].op, directed_rows[row].word + k,
					directed_rows[row].typed, directed_rows[row].res, draw_gap(1));
		hold_until_drained();

		// Random phases, each leaning toward filling, draining or neither.
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == RAND_PHASES / 2)
				hold_until_drained();
			bias      = $urandom_range(0, 2);
			src_style = $urandom_range(0, 2);
			enq_pct   = (bias == 0) ? 65 : (bias == 1) ? 20 : 40;
			deq_pct   = (bias == 0) ? 15 : (bias == 1) ? 40 : 25;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < enq_pct)
					op = MODE_ENQ;
				else if (pick < enq_pct + deq_pct)
					op = MODE_DEQ;
				else if (pick < 95)
					op = MODE_DEL;
				else
					op = MODE_NOP;
				// Deletes mostly aim at a word the queue really holds.
				if (op == MODE_DEL && held_words.size() > 0 && $urandom_range(0, 9) < 7)
					word = held_words[$urandom_range(0, held_words.size() - 1)];
				else
					word = pick_word();
				push_request(op, word, 1'b0, '0, draw_gap(src_style));
			end
		end
		in_valid <= 1'b0;

		// Let every owed result arrive, then keep the clock running before the report.
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("fifo_queue_with_delete: match");
		else
			$display("fifo_queue_with_delete: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fqd_pkg.sv
rtl/fqd_cell.sv
rtl/fifo_queue_with_delete.sv
tb/fifo_queue_with_delete_tb.sv
